@@ sv/nsc_pkg.sv @@
// Shared types, character codes and helpers for the NMEA sentence checksum framer.
// Used by the register block, the sentence parser, the top level and the testbench.
`default_nettype none

package nsc_pkg;

  localparam int unsigned TagW   = 40;
  localparam int unsigned CountW = 3;
  localparam int unsigned DataW  = 64;
  localparam int unsigned AddrW  = 4;

  localparam logic [CountW-1:0] TagLen = 3'd5;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] AlphaOff = 8'h37;

  localparam logic [TagW-1:0] FirstTagRst  = 40'h474E474741;
  localparam logic [TagW-1:0] SecondTagRst = 40'h474E565447;

  // Register select: bit 3 of the byte address picks one of the two 8-byte slots.
  localparam logic RegFirstTag  = 1'b0;
  localparam logic RegSecondTag = 1'b1;

  localparam logic [1:0] KindOther  = 2'd0;
  localparam logic [1:0] KindFirst  = 2'd1;
  localparam logic [1:0] KindSecond = 2'd2;

  typedef struct packed {
    logic [TagW-1:0] first_tag;
    logic [TagW-1:0] second_tag;
  } tags_t;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic       star_found;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
  } result_t;

  // Uppercase hex digit decode: {is_digit, nibble}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= ChZero && c <= ChNine) begin
      v = c - ChZero;
      return {1'b1, v[3:0]};
    end
    if (c >= ChUpperA && c <= ChUpperF) begin
      v = c - AlphaOff;
      return {1'b1, v[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

`default_nettype wire

@@ sv/nsc_if.sv @@
// Valid/ready channel interfaces for the framer: byte requests in, sentence results out.
`default_nettype none

interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic       star_found;
  logic       checksum_ok;
  logic [7:0] computed_checksum;

  modport source (output valid, output sentence_kind, output star_found,
                  output checksum_ok, output computed_checksum, input ready);
  modport sink   (input valid, input sentence_kind, input star_found,
                  input checksum_ok, input computed_checksum, output ready);
endinterface

`default_nettype wire

@@ sv/nsc_apb_regs.sv @@
// APB register block holding the two 5-character sentence tags.
// Depends on nsc_pkg.
`default_nettype none

module nsc_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nsc_pkg::AddrW-1:0]  paddr,
  input  wire logic [nsc_pkg::DataW-1:0]  pwdata,
  output logic      [nsc_pkg::DataW-1:0]  prdata,
  output logic                            pready,
  output nsc_pkg::tags_t                  tags_o
);

  logic [nsc_pkg::TagW-1:0] first_q, second_q;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= nsc_pkg::FirstTagRst;
      second_q <= nsc_pkg::SecondTagRst;
    end else if (wr_en) begin
      if (paddr[3] == nsc_pkg::RegFirstTag) begin
        first_q <= pwdata[nsc_pkg::TagW-1:0];
      end else begin
        second_q <= pwdata[nsc_pkg::TagW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == nsc_pkg::RegSecondTag) begin
      prdata[nsc_pkg::TagW-1:0] = second_q;
    end else begin
      prdata[nsc_pkg::TagW-1:0] = first_q;
    end
  end

  assign tags_o.first_tag  = first_q;
  assign tags_o.second_tag = second_q;

endmodule

`default_nettype wire

@@ sv/nsc_parser.sv @@
// Sentence state: running XOR, star and hex-digit tracking, tag window, and the
// result built on a carriage return. Depends on nsc_pkg.
`default_nettype none

module nsc_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire nsc_pkg::tags_t    tags_i,
  output logic                   ends_sentence_o,
  output nsc_pkg::result_t       result_o
);

  logic                              inside_q, inside_d;
  logic [7:0]                        xor_q, xor_d;
  logic                              star_q, star_d;
  logic [1:0]                        hex_cnt_q, hex_cnt_d;
  logic [7:0]                        rx_val_q, rx_val_d;
  logic                              hex_ok_q, hex_ok_d;
  logic [nsc_pkg::TagW-1:0]          shift_q, shift_d;
  logic [nsc_pkg::CountW-1:0]        tcnt_q, tcnt_d;
  logic                              is_dollar, is_cr;
  logic [4:0]                        nib;

  assign is_dollar       = (byte_i == nsc_pkg::ChDollar);
  assign is_cr           = (byte_i == nsc_pkg::ChCr);
  assign nib             = nsc_pkg::hex_nibble(byte_i);
  assign ends_sentence_o = is_cr && inside_q;

  // Result from the state the carriage return finds.
  always_comb begin
    result_o.sentence_kind = nsc_pkg::KindOther;
    if (tcnt_q == nsc_pkg::TagLen) begin
      if (shift_q == tags_i.first_tag) begin
        result_o.sentence_kind = nsc_pkg::KindFirst;
      end else if (shift_q == tags_i.second_tag) begin
        result_o.sentence_kind = nsc_pkg::KindSecond;
      end
    end
    result_o.star_found        = star_q;
    result_o.checksum_ok       = star_q && (hex_cnt_q == 2'd2) && hex_ok_q &&
                                 (rx_val_q == xor_q);
    result_o.computed_checksum = xor_q;
  end

  always_comb begin
    inside_d  = inside_q;
    xor_d     = xor_q;
    star_d    = star_q;
    hex_cnt_d = hex_cnt_q;
    rx_val_d  = rx_val_q;
    hex_ok_d  = hex_ok_q;
    shift_d   = shift_q;
    tcnt_d    = tcnt_q;
    if (is_dollar) begin
      // open or restart: clear all sentence state
      inside_d  = 1'b1;
      xor_d     = '0;
      star_d    = 1'b0;
      hex_cnt_d = '0;
      rx_val_d  = '0;
      hex_ok_d  = 1'b1;
      shift_d   = '0;
      tcnt_d    = '0;
    end else if (is_cr) begin
      inside_d = 1'b0;
    end else if (inside_q) begin
      if (tcnt_q < nsc_pkg::TagLen) begin
        shift_d = {shift_q[nsc_pkg::TagW-9:0], byte_i};
        tcnt_d  = tcnt_q + 3'd1;
      end
      if (!star_q) begin
        if (byte_i == nsc_pkg::ChStar) begin
          star_d = 1'b1;
        end else begin
          xor_d = xor_q ^ byte_i;
        end
      end else if (hex_cnt_q < 2'd2) begin
        if (!nib[4]) begin
          hex_ok_d = 1'b0;
        end
        rx_val_d  = {rx_val_q[3:0], nib[3:0]};
        hex_cnt_d = hex_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      xor_q     <= '0;
      star_q    <= 1'b0;
      hex_cnt_q <= '0;
      rx_val_q  <= '0;
      hex_ok_q  <= 1'b1;
      shift_q   <= '0;
      tcnt_q    <= '0;
    end else if (step_i) begin
      inside_q  <= inside_d;
      xor_q     <= xor_d;
      star_q    <= star_d;
      hex_cnt_q <= hex_cnt_d;
      rx_val_q  <= rx_val_d;
      hex_ok_q  <= hex_ok_d;
      shift_q   <= shift_d;
      tcnt_q    <= tcnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/nmea_sentence_checksum_framer_top.sv @@
// NMEA sentence checksum framer: byte register, sentence parser, result register.
// A carriage return's result passes through the byte register, then the result register.
// Throughput: one byte per cycle; the byte register stalls only while it holds a sentence-ending CR and a result waits.
// Reset (rst_ni, async low): sentence state cleared, tags back to GNGGA and GNVTG.
// Depends on nsc_pkg, nsc_if, nsc_apb_regs and nsc_parser.
`default_nettype none

module nmea_sentence_checksum_framer_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  nsc_byte_if.sink                        byte_i,
  nsc_result_if.source                    result_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nsc_pkg::AddrW-1:0]  paddr,
  input  wire logic [nsc_pkg::DataW-1:0]  pwdata,
  output logic      [nsc_pkg::DataW-1:0]  prdata,
  output logic                            pready
);

  nsc_pkg::tags_t   tags;
  nsc_pkg::result_t res, out_q;
  logic             s_valid_q;
  logic [7:0]       s_byte_q;
  logic             out_valid_q;
  logic             ends_sentence, out_free, s_go, step;

  nsc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tags_o  (tags)
  );

  nsc_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .byte_i          (s_byte_q),
    .tags_i          (tags),
    .ends_sentence_o (ends_sentence),
    .result_o        (res)
  );

  // Hold the byte only when it produces a result and the result slot is full.
  assign out_free     = !out_valid_q || result_o.ready;
  assign s_go         = !ends_sentence || out_free;
  assign step         = s_valid_q && s_go;
  assign byte_i.ready = !s_valid_q || s_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      s_byte_q <= byte_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && ends_sentence;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && ends_sentence) begin
      out_q <= res;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.sentence_kind     = out_q.sentence_kind;
  assign result_o.star_found        = out_q.star_found;
  assign result_o.checksum_ok       = out_q.checksum_ok;
  assign result_o.computed_checksum = out_q.computed_checksum;

endmodule

`default_nettype wire

@@ tb/tb_nmea_sentence_checksum_framer_top.sv @@
// Self-checking testbench for the NMEA sentence checksum framer: byte requests in,
// sentence results out, tag registers written over APB. Depends on nsc_pkg, nsc_if
// and the RTL top level.
module tb_nmea_sentence_checksum_framer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  localparam time ClkPeriod  = 20ns;
  localparam int  ResetLen   = 9;
  localparam int  MaxWait    = 18;
  localparam int  LongHold   = 400;
  localparam int  HoldAfter  = 12;
  localparam int  StallLimit = 4000;
  localparam int  Settle     = 4;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTilde  = 8'h7E;

  localparam logic [AddrW-1:0] AddrFirstTag  = {RegFirstTag, 3'b000};
  localparam logic [AddrW-1:0] AddrSecondTag = {RegSecondTag, 3'b000};
  localparam logic [TagW-1:0]  TagAllOnes    = '1;

  typedef enum int unsigned {
    SumGood, SumWrong, SumBadDigit, SumMissing, SumShort, SumLong, SumCut
  } sum_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  nsc_byte_if   byte_if ();
  nsc_result_if result_if ();

  nmea_sentence_checksum_framer_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Tag mirror and sentence state of the predictor.
  logic [TagW-1:0]   tag_first    = FirstTagRst;
  logic [TagW-1:0]   tag_second   = SecondTagRst;
  logic              in_sentence  = 1'b0;
  logic [7:0]        run_xor      = 8'h00;
  logic              past_star    = 1'b0;
  logic [1:0]        hex_count    = 2'd0;
  logic [7:0]        rx_value     = 8'h00;
  logic              hex_ok       = 1'b1;
  logic [TagW-1:0]   tag_shift    = '0;
  logic [CountW-1:0] tag_count    = '0;

  logic [7:0] uart_bytes[$];
  result_t    expected_sentences[$];
  int         bytes_queued = 0;
  int         mismatches   = 0;
  int         results_seen = 0;
  int         send_wait    = 0;
  int         recv_wait    = 0;
  int         idle_cycles  = 0;
  bit         send_calm    = 1'b0;
  bit         recv_calm    = 1'b0;
  logic       any_accept;

  assign any_accept = (byte_if.valid && byte_if.ready) ||
                      (result_if.valid && result_if.ready) ||
                      (psel && penable && pready);

  // Advance the sentence state by one byte; returns 1 when a sentence ends.
  function automatic bit frame_byte(input logic [7:0] b, output result_t res);
    logic [7:0] nib;
    res = '0;
    if (b == ChDollar) begin
      in_sentence = 1'b1;
      run_xor     = 8'h00;
      past_star   = 1'b0;
      hex_count   = 2'd0;
      rx_value    = 8'h00;
      hex_ok      = 1'b1;
      tag_shift   = '0;
      tag_count   = '0;
      return 1'b0;
    end
    if (b == ChCr) begin
      if (!in_sentence) return 1'b0;
      res.sentence_kind = KindOther;
      if (tag_count == TagLen) begin
        if (tag_shift == tag_first) res.sentence_kind = KindFirst;
        else if (tag_shift == tag_second) res.sentence_kind = KindSecond;
      end
      res.star_found        = past_star;
      res.checksum_ok       = past_star && hex_count == 2'd2 && hex_ok && rx_value == run_xor;
      res.computed_checksum = run_xor;
      in_sentence = 1'b0;
      return 1'b1;
    end
    if (!in_sentence) return 1'b0;
    if (tag_count < TagLen) begin
      tag_shift = {tag_shift[TagW-9:0], b};
      tag_count = tag_count + 1'b1;
    end
    if (!past_star) begin
      if (b == ChStar) past_star = 1'b1;
      else run_xor = run_xor ^ b;
    end else if (hex_count < 2'd2) begin
      if (b >= ChZero && b <= ChNine) begin
        nib = b - ChZero;
      end else if (b >= ChUpperA && b <= ChUpperF) begin
        nib = b - AlphaOff;
      end else begin
        nib    = 8'h00;
        hex_ok = 1'b0;
      end
      rx_value  = {rx_value[3:0], nib[3:0]};
      hex_count = hex_count + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Byte driver: one request per queued byte, random gap after each accepted one unless send_calm is set.
  always @(posedge clk_i) begin : drive_bytes
    result_t res;
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        if (frame_byte(byte_if.data_byte, res)) expected_sentences.push_back(res);
        send_wait = send_calm ? 0 : $urandom_range(0, MaxWait);
      end
      if (byte_if.valid && !byte_if.ready) begin
        // hold the request until it is taken
      end else if (send_wait > 0) begin
        byte_if.valid <= 1'b0;
        send_wait--;
      end else if (uart_bytes.size() != 0) begin
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= uart_bytes.pop_front();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare with the oldest pending sentence, then stall at random unless recv_calm is set.
  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_sentences.size() == 0) begin
          $error("result with no sentence pending: kind %0d, checksum 0x%0h",
                 result_if.sentence_kind, result_if.computed_checksum);
          mismatches++;
        end else begin
          want = expected_sentences.pop_front();
          check_field("sentence_kind", 8'(want.sentence_kind), 8'(result_if.sentence_kind));
          check_field("star_found", 8'(want.star_found), 8'(result_if.star_found));
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(result_if.checksum_ok));
          check_field("computed_checksum", want.computed_checksum,
                      result_if.computed_checksum);
        end
        results_seen++;
        recv_wait = recv_calm ? 0 : $urandom_range(0, MaxWait);
        // hold off long enough for the byte side to back up
        if (results_seen == HoldAfter) recv_wait = LongHold;
      end
      if (recv_wait > 0) begin
        result_if.ready <= 1'b0;
        recv_wait--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || any_accept) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    uart_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? ChZero + 8'(n) : AlphaOff + 8'(n);
  endfunction

  // Field character: mostly printable, sometimes any byte that keeps the frame intact.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(ChSpace, ChTilde));
    end while (c == ChDollar || c == ChStar || c == ChCr);
    return c;
  endfunction

  // Character that is not an uppercase hex digit, biased to the range edges.
  function automatic logic [7:0] bad_digit();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(ChLowerA, ChLowerF));
      1:       return ChZero - 8'd1;
      2:       return 8'($urandom_range(ChNine + 8'd1, ChUpperA - 8'd1));
      default: return 8'($urandom_range(ChUpperF + 8'd1, ChUpperZ));
    endcase
  endfunction

  function automatic logic [TagW-1:0] letters_tag();
    logic [TagW-1:0] t;
    t = '0;
    repeat (TagLen) t = {t[TagW-9:0], 8'($urandom_range(ChUpperA, ChUpperZ))};
    return t;
  endfunction

  task automatic queue_sentence(input logic [TagW-1:0] tag, input int tag_len,
                                input int body_len, input sum_style_e style);
    logic [7:0] sum;
    logic [7:0] c;
    int         bad_pos;
    sum = 8'h00;
    put_byte(ChDollar);
    for (int k = 0; k < tag_len; k++) begin
      c = tag[TagW-1-8*k -: 8];
      put_byte(c);
      sum ^= c;
    end
    repeat (body_len) begin
      c = body_char();
      put_byte(c);
      sum ^= c;
    end
    if (style == SumWrong) sum ^= 8'($urandom_range(1, 255));
    case (style)
      SumGood, SumWrong: begin
        put_byte(ChStar);
        put_byte(hex_char(sum[7:4]));
        put_byte(hex_char(sum[3:0]));
      end
      SumBadDigit: begin
        bad_pos = $urandom_range(0, 1);
        put_byte(ChStar);
        put_byte(bad_pos == 0 ? bad_digit() : hex_char(sum[7:4]));
        put_byte(bad_pos == 1 ? bad_digit() : hex_char(sum[3:0]));
      end
      SumShort: begin
        put_byte(ChStar);
        if ($urandom_range(0, 1)) put_byte(hex_char(sum[3:0]));
      end
      SumLong: begin
        put_byte(ChStar);
        put_byte(hex_char(sum[7:4]));
        put_byte(hex_char(sum[3:0]));
        repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 3) == 0 ? ChStar : body_char());
      end
      SumCut: begin
        if ($urandom_range(0, 1)) put_byte(ChStar);
      end
      default: begin
      end
    endcase
    if (style != SumCut) begin
      put_byte(ChCr);
      if ($urandom_range(0, 1)) put_byte(ChLf);
    end
  endtask

  // Mostly well-formed sentences, some cut short, some line noise in between.
  task automatic queue_traffic(input int n_bytes);
    logic [TagW-1:0] tag;
    int              tag_len;
    int              pos;
    int              goal;
    sum_style_e      style;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) begin
      tag_len = TagLen;
      case ($urandom_range(0, 9))
        0, 1, 2: tag = tag_first;
        3, 4, 5: tag = tag_second;
        6:       tag = letters_tag();
        7: begin
          tag = tag_first;
          pos = $urandom_range(0, 4);
          tag[8*pos +: 8] ^= 8'(1 << $urandom_range(0, 7));
        end
        8: begin
          tag     = letters_tag();
          tag_len = $urandom_range(0, 4);
        end
        default: tag = {8'($urandom), 32'($urandom)};
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: style = SumGood;
        4:          style = SumWrong;
        5:          style = SumBadDigit;
        6:          style = SumMissing;
        7:          style = SumShort;
        default:    style = SumLong;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0:       put_byte(ChCr);
              1:       put_byte(ChLf);
              default: put_byte(8'($urandom));
            endcase
          end
        end
        1:       queue_sentence(tag, tag_len, $urandom_range(0, 8), SumCut);
        default: queue_sentence(tag, tag_len, $urandom_range(0, 12), style);
      endcase
    end
  endtask

  // Wait until every byte is taken and every sentence reported, then let the pipe empty.
  task automatic settle();
    while (uart_bytes.size() != 0 || byte_if.valid || expected_sentences.size() != 0)
      @(negedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_tag(input logic [AddrW-1:0] addr, input logic [TagW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(DataW - TagW)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrFirstTag) tag_first = value;
    else tag_second = value;
    @(negedge clk_i);
  endtask

  initial begin
    logic [TagW-1:0] shared_tag;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    result_if.ready   = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_ni            = 1'b0;
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // stray CR, short tag, extra checksum chars, short and lowercase checksum, restart
    queue_text("\r$A*41\r$GNGGA*48Z\r$*4\r$*0a\r$$GNVTG\r");
    put_byte(ChDollar);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(ChCr);
    queue_traffic(300);

    settle();
    write_tag(AddrFirstTag, letters_tag());
    write_tag(AddrSecondTag, {8'($urandom), 32'($urandom)});
    send_calm = 1'b1;
    queue_traffic(250);

    // equal tags: the first one wins
    settle();
    shared_tag = letters_tag();
    write_tag(AddrFirstTag, shared_tag);
    write_tag(AddrSecondTag, shared_tag);
    send_calm = 1'b0;
    recv_calm = 1'b1;
    queue_traffic(250);

    settle();
    write_tag(AddrFirstTag, '0);
    write_tag(AddrSecondTag, TagAllOnes);
    send_calm = 1'b1;
    queue_traffic(200);

    settle();
    write_tag(AddrFirstTag, TagAllOnes);
    write_tag(AddrSecondTag, '0);
    send_calm = 1'b0;
    recv_calm = 1'b0;
    queue_traffic(250);

    settle();
    repeat (2 * Settle) @(posedge clk_i);
    if (mismatches == 0 && expected_sentences.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
